// ===== hdl/mse_pkg.sv =====
// ---------------------------------------------------------------------------
// Mandelbrot smooth escape package
// Shared widths, register indexes, the cell hand-off record and a saturate helper.
// ---------------------------------------------------------------------------
package mse_pkg;

   localparam int FRAC_BITS   = 28;
   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int QUO_BITS    = 9;
   localparam int NUM_CELLS   = QUO_BITS;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_X_START    = 3'd0,
      REG_Y_START    = 3'd1,
      REG_STEP_X     = 3'd2,
      REG_STEP_Y     = 3'd3,
      REG_MAX_ITER   = 3'd4,
      REG_GREY_SCALE = 3'd5
   } reg_index_type;

   // Data one divider cell hands to the next.
   typedef struct packed {
      logic [36:0] rem;
      logic [36:0] den;
      logic [8:0]  quo;
   } div_token_type;

   // Saturate a 64-bit signed value to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      r = v[31:0];
      if (v > 64'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -64'sd2147483648) r = 32'sh80000000;
      return r;
   endfunction

endpackage

// ===== hdl/mse_if.sv =====
// ---------------------------------------------------------------------------
// Mandelbrot request and result channels
// Valid/ready channels carrying pixel requests and escape results.
// ---------------------------------------------------------------------------
interface mse_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] pixel_x;
   logic [11:0] pixel_y;
   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mse_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  grey_level;
   logic [15:0] smooth_value;
   logic [7:0]  iteration_count;
   logic        escaped;
   modport source (output valid, output grey_level, output smooth_value,
                   output iteration_count, output escaped, input ready);
   modport sink   (input valid, input grey_level, input smooth_value,
                   input iteration_count, input escaped, output ready);
endinterface

// ===== hdl/mandelbrot_smooth_escape_pixel.sv =====
// ---------------------------------------------------------------------------
// Mandelbrot smooth escape pixel
// Escape-time evaluator with interpolated smooth value and grey byte.
// ---------------------------------------------------------------------------
// Usage: write the viewport and limits over the csr_ port while idle, then
// send pixel requests on req_. One result per request comes on rsp_.
// One request is worked at a time. It passes the setup phases, then the
// squaring passes (the shared multiplier pair does squares, then the cross
// product), then the row of divider cells and the grey multiply and output
// register. The number of passes is the steps done, plus one for the test
// that escapes. req_ready is low from acceptance until the result is taken.
// A stalled result waits in the output register. Reset is synchronous and
// restores max_iter 50, grey scale 5.0 and a zero viewport.
// ---------------------------------------------------------------------------
module mandelbrot_smooth_escape_pixel (
   input  logic        clock,
   input  logic        reset,
   mse_req_if.sink     req,
   mse_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mse_pkg::*;

   logic signed [31:0] xs_ff, ys_ff, sx_ff, sy_ff;
   logic [7:0]         mi_ff;
   logic [15:0]        gs_ff;
   logic               busy_ff, busy_in;
   logic [11:0]        px_ff, py_ff;
   logic               start;
   logic               it_done, it_esc;
   logic [7:0]         it_cnt;
   logic [35:0]        it_num, it_den;
   reg_index_type      widx;
   div_token_type      tok [NUM_CELLS+1];
   logic [NUM_CELLS-1:0] dv_ff;
   logic               esc_p_ff [NUM_CELLS];
   logic [7:0]         cnt_p_ff [NUM_CELLS];
   logic [15:0]        sm_ff, sm_in;
   logic               g_ff, rv_ff;
   logic               g_esc_ff;
   logic [7:0]         g_cnt_ff;
   logic [31:0]        gprod;
   logic [16:0]        s_sum;

   assign csr_pready = 1'b1;
   assign widx = reg_index_type'(csr_paddr[4:2]);

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         xs_ff <= '0; ys_ff <= '0; sx_ff <= '0; sy_ff <= '0;
         mi_ff <= 8'd50; gs_ff <= 16'd1280;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (widx)
            REG_X_START:    xs_ff <= csr_pwdata;
            REG_Y_START:    ys_ff <= csr_pwdata;
            REG_STEP_X:     sx_ff <= csr_pwdata;
            REG_STEP_Y:     sy_ff <= csr_pwdata;
            REG_MAX_ITER:   mi_ff <= csr_pwdata[7:0];
            REG_GREY_SCALE: gs_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      case (widx)
         REG_X_START:    csr_prdata = xs_ff;
         REG_Y_START:    csr_prdata = ys_ff;
         REG_STEP_X:     csr_prdata = sx_ff;
         REG_STEP_Y:     csr_prdata = sy_ff;
         REG_MAX_ITER:   csr_prdata = {24'd0, mi_ff};
         REG_GREY_SCALE: csr_prdata = {16'd0, gs_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // Request acceptance; busy until the result is taken.
   assign req.ready = !busy_ff;
   assign start = req.valid && !busy_ff;
   assign busy_in = start ? 1'b1 : ((rsp.valid && rsp.ready) ? 1'b0 : busy_ff);

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
      if (start) begin
         px_ff <= req.pixel_x; py_ff <= req.pixel_y;
      end
   end

   mse_iter u_iter (
      .clock(clock), .reset(reset), .start_i(start),
      .px_i(px_ff), .py_i(py_ff),
      .x_start_i(xs_ff), .y_start_i(ys_ff), .step_x_i(sx_ff), .step_y_i(sy_ff),
      .max_iter_i(mi_ff), .done_o(it_done), .esc_o(it_esc), .count_o(it_cnt),
      .num_o(it_num), .den_o(it_den)
   );

   // Row of divider cells. The denominator enters doubled, so nine shifting
   // steps give floor(num * 256 / den), which reaches 256 when num equals den.
   assign tok[0] = '{rem: {1'b0, it_num}, den: {it_den, 1'b0}, quo: 9'd0};

   genvar g;
   generate
      for (g = 0; g < NUM_CELLS; g++) begin : g_cell
         mse_div_cell u_cell (.clock(clock), .tok_i(tok[g]), .tok_o(tok[g+1]));
      end
   endgenerate

   // Side data walks alongside the cells.
   always_ff @(posedge clock) begin
      if (reset) dv_ff <= '0;
      else       dv_ff <= {dv_ff[NUM_CELLS-2:0], it_done};
      esc_p_ff[0] <= it_esc;
      cnt_p_ff[0] <= it_cnt;
      for (int k = 1; k < NUM_CELLS; k++) begin
         esc_p_ff[k] <= esc_p_ff[k-1];
         cnt_p_ff[k] <= cnt_p_ff[k-1];
      end
   end

   // Smooth value: i*256 + frac - 256, clamped to zero; interior is max_iter.
   always_comb begin
      s_sum = {1'b0, cnt_p_ff[NUM_CELLS-1], 8'd0} + {8'd0, tok[NUM_CELLS].quo};
      if (!esc_p_ff[NUM_CELLS-1]) sm_in = {mi_ff, 8'd0};
      else if (s_sum >= 17'd256) sm_in = (s_sum - 17'd256 > 17'hFFFF) ?
                                          16'hFFFF : 16'(s_sum - 17'd256);
      else sm_in = '0;
   end

   assign gprod = sm_ff * gs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         g_ff <= dv_ff[NUM_CELLS-1];
         if (g_ff) rv_ff <= 1'b1;
         else if (rsp.ready) rv_ff <= 1'b0;
      end
      if (dv_ff[NUM_CELLS-1]) begin
         sm_ff    <= sm_in;
         g_esc_ff <= esc_p_ff[NUM_CELLS-1];
         g_cnt_ff <= esc_p_ff[NUM_CELLS-1] ? cnt_p_ff[NUM_CELLS-1] : mi_ff;
      end
      if (g_ff) begin
         rsp.grey_level      <= (gprod[31:24] != 8'd0) ? 8'hFF : gprod[23:16];
         rsp.smooth_value    <= sm_ff;
         rsp.iteration_count <= g_cnt_ff;
         rsp.escaped         <= g_esc_ff;
      end
   end

   assign rsp.valid = rv_ff;

   // A result appears only while a request is in flight.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> busy_ff) else $error("result without request");
   // No new request is taken while a result waits.
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !req.ready) else $error("accept during result");
   // The divider row holds at most one item at a time.
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(dv_ff) <= 1) else $error("two items in divider");
endmodule

// ===== hdl/mse_div_cell.sv =====
// ---------------------------------------------------------------------------
// Mandelbrot divider cell
// One restoring-division step; the row of cells forms the quotient.
// ---------------------------------------------------------------------------
module mse_div_cell (
   input  logic                   clock,
   input  mse_pkg::div_token_type tok_i,
   output mse_pkg::div_token_type tok_o
);
   import mse_pkg::*;

   div_token_type tok_ff, tok_in;
   logic [37:0]   shifted;
   logic [37:0]   diff;

   // Shift the remainder, try a subtract of the denominator.
   always_comb begin
      shifted = {tok_i.rem, 1'b0};
      diff    = shifted - {1'b0, tok_i.den};
      tok_in.den = tok_i.den;
      if (!diff[37]) begin
         tok_in.rem = diff[36:0];
         tok_in.quo = {tok_i.quo[7:0], 1'b1};
      end else begin
         tok_in.rem = shifted[36:0];
         tok_in.quo = {tok_i.quo[7:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
   end

   assign tok_o = tok_ff;
endmodule

// ===== hdl/mse_iter.sv =====
// ---------------------------------------------------------------------------
// Mandelbrot iteration unit
// Forms c, then runs z = z*z + c one product phase per cycle.
// ---------------------------------------------------------------------------
module mse_iter (
   input  logic               clock,
   input  logic               reset,
   input  logic               start_i,
   input  logic [11:0]        px_i,
   input  logic [11:0]        py_i,
   input  logic signed [31:0] x_start_i,
   input  logic signed [31:0] y_start_i,
   input  logic signed [31:0] step_x_i,
   input  logic signed [31:0] step_y_i,
   input  logic [7:0]         max_iter_i,
   output logic               done_o,
   output logic               esc_o,
   output logic [7:0]         count_o,
   output logic [35:0]        num_o,
   output logic [35:0]        den_o
);
   import mse_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_CMUL = 5'b00010,
      S_CADD = 5'b00100,
      S_SQR  = 5'b01000,
      S_CROSS= 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic signed [31:0] cr_ff, ci_ff, zr_ff, zi_ff, cr_in, ci_in, zr_in, zi_in;
   logic signed [63:0] rr_ff, ii_ff, rr_in, ii_in;
   logic [63:0]        old_ff, old_in;
   logic [7:0]         cnt_ff, cnt_in;
   logic               done_ff, done_in, esc_ff, esc_in;
   logic [35:0]        num_ff, num_in, den_ff, den_in;
   logic signed [63:0] prod_a, prod_b, mag_sum, nr, ni;
   logic [63:0]        mag;

   // Shared multiplier pair; its use depends on the phase.
   always_comb begin
      if (state_ff == S_CMUL) begin
         prod_a = $signed({20'd0, px_i}) * $signed(step_x_i);
         prod_b = $signed({20'd0, py_i}) * $signed(step_y_i);
      end else if (state_ff == S_CROSS) begin
         prod_a = zr_ff * zi_ff;
         prod_b = '0;
      end else begin
         prod_a = zr_ff * zr_ff;
         prod_b = zi_ff * zi_ff;
      end
   end

   always_comb begin
      mag_sum = rr_ff + ii_ff;
      mag     = {28'd0, mag_sum[63:28]};
      nr      = ((rr_ff - ii_ff) >>> FRAC_BITS) + 64'(cr_ff);
      ni      = (prod_a >>> (FRAC_BITS - 1)) + 64'(ci_ff);
   end

   // Sequencer over setup, squaring and cross-product phases.
   always_comb begin
      state_in = state_ff;
      cr_in = cr_ff; ci_in = ci_ff; zr_in = zr_ff; zi_in = zi_ff;
      rr_in = rr_ff; ii_in = ii_ff; old_in = old_ff; cnt_in = cnt_ff;
      done_in = 1'b0; esc_in = esc_ff; num_in = num_ff; den_in = den_ff;
      case (state_ff)
         S_IDLE: begin
            if (start_i) begin
               state_in = S_CMUL;
               old_in = '0; cnt_in = '0; esc_in = 1'b0;
            end
         end
         S_CMUL: begin
            rr_in = prod_a; ii_in = prod_b;
            state_in = S_CADD;
         end
         S_CADD: begin
            cr_in = sat32(64'(x_start_i) + rr_ff);
            ci_in = sat32(64'(y_start_i) + ii_ff);
            zr_in = cr_in; zi_in = ci_in;
            if (max_iter_i == 8'd0) begin
               done_in = 1'b1; state_in = S_IDLE;
               num_in = '0; den_in = 36'd1;
            end else begin
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            rr_in = prod_a; ii_in = prod_b;
            state_in = S_CROSS;
         end
         default: begin
            if (mag >= (64'd4 << FRAC_BITS)) begin
               esc_in = 1'b1; done_in = 1'b1; state_in = S_IDLE;
               num_in = 36'((64'd4 << FRAC_BITS) - old_ff);
               den_in = 36'(mag - old_ff);
            end else begin
               zr_in = sat32(nr); zi_in = sat32(ni);
               old_in = mag;
               cnt_in = cnt_ff + 8'd1;
               if (cnt_in == max_iter_i) begin
                  done_in = 1'b1; state_in = S_IDLE;
                  num_in = '0; den_in = 36'd1;
               end else begin
                  state_in = S_SQR;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cr_ff <= cr_in; ci_ff <= ci_in; zr_ff <= zr_in; zi_ff <= zi_in;
      rr_ff <= rr_in; ii_ff <= ii_in; old_ff <= old_in; cnt_ff <= cnt_in;
      esc_ff <= esc_in; num_ff <= num_in; den_ff <= den_in;
   end

   assign done_o  = done_ff;
   assign esc_o   = esc_ff;
   assign count_o = cnt_ff;
   assign num_o   = num_ff;
   assign den_o   = den_ff;

   // A finish pulse lasts a single cycle.
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("done held");
   // Escape is only reported with a count below the limit.
   a_esc_count: assert property (@(posedge clock) disable iff (reset)
      (done_ff && esc_ff) |-> (cnt_ff < max_iter_i)) else $error("bad count");
   // Iteration starts only from idle.
   a_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMUL) |-> $past(state_ff == S_IDLE)) else $error("bad start");
endmodule
